@@ hdl/kst_pkg.sv @@
`timescale 1ns / 1ps

package kst_pkg;

  localparam int SampleBits = 12;
  localparam logic [SampleBits-1:0] MatchWindowReset = SampleBits'(41);

  typedef logic [SampleBits-1:0] sample_t;

  typedef enum logic [2:0] {
    SEL_NONE   = 3'd0,
    SEL_LIGHT  = 3'd1,
    SEL_SPEED  = 3'd2,
    SEL_OFFSET = 3'd3,
    SEL_WIDTH  = 3'd4
  } mode_t;

  typedef struct packed {
    sample_t pot_sample;
    logic    switch_light;
    logic    switch_speed;
    logic    switch_offset;
    logic    switch_width;
  } in_item_t;

  typedef struct packed {
    logic       led_left;
    logic       led_right;
    logic [2:0] active_mode;
    logic       is_aligned;
    sample_t    light_out;
    sample_t    speed_out;
    sample_t    offset_out;
    sample_t    width_out;
  } out_item_t;

  // handshake between the input register and the update stage
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

@@ hdl/kst_in_stage.sv @@
`timescale 1ns / 1ps

module kst_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kst_pkg::in_item_t  in_data,
  input  logic               out_busy,
  output kst_pkg::stage_ctl_t ctl,
  output kst_pkg::in_item_t  item
);
  import kst_pkg::*;

  logic     vld_r, vld_nxt;
  in_item_t item_r;
  logic     adv;
  logic     take;

  // the held beat moves on whenever the result register can take it
  assign adv      = vld_r && !out_busy;
  assign in_stall = vld_r && out_busy;
  assign take     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_data;
    end
  end

  assign ctl.valid   = vld_r;
  assign ctl.advance = adv;
  assign item        = item_r;

endmodule

@@ hdl/kst_engine.sv @@
`timescale 1ns / 1ps

module kst_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  kst_pkg::stage_ctl_t ctl,
  input  kst_pkg::in_item_t   item,
  input  kst_pkg::sample_t    match_window,
  output kst_pkg::out_item_t  result
);
  import kst_pkg::*;

  mode_t   last_mode_r, last_mode_nxt;
  logic    aligned_r, aligned_nxt;
  logic    led_left_r, led_left_nxt;
  logic    led_right_r, led_right_nxt;
  sample_t light_r, light_nxt;
  sample_t speed_r, speed_nxt;
  sample_t offset_r, offset_nxt;
  sample_t width_r, width_nxt;

  mode_t   mode;
  logic    aligned_cur;
  sample_t cur;
  sample_t gap;

  always_comb begin
    if (item.switch_light) begin
      mode = SEL_LIGHT;
    end else if (item.switch_speed) begin
      mode = SEL_SPEED;
    end else if (item.switch_offset) begin
      mode = SEL_OFFSET;
    end else if (item.switch_width) begin
      mode = SEL_WIDTH;
    end else begin
      mode = SEL_NONE;
    end
  end

  // a new selection drops the pickup
  assign aligned_cur = (mode == last_mode_r) ? aligned_r : 1'b0;

  always_comb begin
    case (mode)
      SEL_LIGHT:  cur = light_r;
      SEL_SPEED:  cur = speed_r;
      SEL_OFFSET: cur = offset_r;
      SEL_WIDTH:  cur = width_r;
      default:    cur = '0;
    endcase
  end

  assign gap = (item.pot_sample >= cur) ? (item.pot_sample - cur) : (cur - item.pot_sample);

  always_comb begin
    last_mode_nxt = mode;
    aligned_nxt   = aligned_cur;
    led_left_nxt  = led_left_r;
    led_right_nxt = led_right_r;
    light_nxt     = light_r;
    speed_nxt     = speed_r;
    offset_nxt    = offset_r;
    width_nxt     = width_r;
    if (mode == SEL_NONE) begin
      led_left_nxt  = 1'b0;
      led_right_nxt = 1'b0;
    end else if (aligned_cur) begin
      // knob drives the selected level, leds hold
      case (mode)
        SEL_LIGHT:  light_nxt  = item.pot_sample;
        SEL_SPEED:  speed_nxt  = item.pot_sample;
        SEL_OFFSET: offset_nxt = item.pot_sample;
        SEL_WIDTH:  width_nxt  = item.pot_sample;
        default:    light_nxt  = light_r;
      endcase
    end else if (gap < match_window) begin
      led_left_nxt  = 1'b1;
      led_right_nxt = 1'b1;
      aligned_nxt   = 1'b1;
    end else if (item.pot_sample > cur) begin
      led_left_nxt  = 1'b1;
      led_right_nxt = 1'b0;
    end else begin
      led_left_nxt  = 1'b0;
      led_right_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_mode_r <= SEL_NONE;
      aligned_r   <= 1'b0;
      led_left_r  <= 1'b0;
      led_right_r <= 1'b0;
      light_r     <= '0;
      speed_r     <= '0;
      offset_r    <= '0;
      width_r     <= '0;
    end else if (ctl.advance) begin
      last_mode_r <= last_mode_nxt;
      aligned_r   <= aligned_nxt;
      led_left_r  <= led_left_nxt;
      led_right_r <= led_right_nxt;
      light_r     <= light_nxt;
      speed_r     <= speed_nxt;
      offset_r    <= offset_nxt;
      width_r     <= width_nxt;
    end
  end

  assign result.led_left    = led_left_nxt;
  assign result.led_right   = led_right_nxt;
  assign result.active_mode = last_mode_nxt;
  assign result.is_aligned  = aligned_nxt;
  assign result.light_out   = light_nxt;
  assign result.speed_out   = speed_nxt;
  assign result.offset_out  = offset_nxt;
  assign result.width_out   = width_nxt;

  a_none_not_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (last_mode_r == SEL_NONE) |-> !aligned_r)
    else $error("aligned with no selection");

  a_pickup_lights_both: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(aligned_r)) |-> (led_left_r && led_right_r))
    else $error("pickup without both leds");

  a_light_written_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(light_r)) |-> ($past(aligned_r) && aligned_r))
    else $error("light level written while not aligned");

  a_advance_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.advance |-> ctl.valid)
    else $error("update without a held beat");

endmodule

@@ hdl/kst_out_stage.sv @@
`timescale 1ns / 1ps

module kst_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  kst_pkg::stage_ctl_t ctl,
  input  kst_pkg::out_item_t  result,
  output logic                out_busy,
  output logic                out_valid,
  input  logic                out_stall,
  output kst_pkg::out_item_t  out_data
);
  import kst_pkg::*;

  logic      vld_r, vld_nxt;
  out_item_t data_r;

  assign out_busy = vld_r && out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (ctl.advance) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      data_r <= result;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

@@ hdl/knob_soft_takeover_top.sv @@
`timescale 1ns / 1ps

// Soft-takeover for one 12-bit knob shared by four stored levels (light, speed,
// offset, width). Each input beat is one sample; the highest-priority set switch
// selects the level. Until the knob comes closer than match_window counts to the
// stored level, the leds show which way to turn; once caught, the knob writes
// the level on every following beat of that selection. Every beat yields one
// result beat with the levels as they stand after that sample. A beat passes
// through the input register and the update into the result register; a beat
// can enter every cycle unless the output stalls. Level and pickup state live in
// one register stage, so back-to-back samples of the same knob need no forwarding.
// match_window resets to 41 and should only be written while no beat is in flight.
module knob_soft_takeover_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output kst_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  kst_pkg::sample_t   cfg_wdata
);
  import kst_pkg::*;

  sample_t    match_window_r;
  stage_ctl_t ctl;
  in_item_t   item;
  out_item_t  result;
  logic       out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_window_r <= MatchWindowReset;
    end else if (cfg_we) begin
      match_window_r <= cfg_wdata;
    end
  end

  kst_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_busy (out_busy),
    .ctl      (ctl),
    .item     (item)
  );

  kst_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .item         (item),
    .match_window (match_window_r),
    .result       (result)
  );

  kst_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .result    (result),
    .out_busy  (out_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ test/tb_knob_soft_takeover_top.sv @@
`timescale 1ns / 1ps

module tb_knob_soft_takeover_top;
  import kst_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int SampleMax = (1 << SampleBits) - 1;

  // switch patterns, ordered {light, speed, offset, width}
  localparam logic [3:0] SW_NONE   = 4'b0000;
  localparam logic [3:0] SW_LIGHT  = 4'b1000;
  localparam logic [3:0] SW_SPEED  = 4'b0100;
  localparam logic [3:0] SW_OFFSET = 4'b0010;
  localparam logic [3:0] SW_WIDTH  = 4'b0001;
  localparam logic [3:0] SW_ALL    = 4'b1111;

  class takeover_board;
    sample_t   window;
    mode_t     mode;
    logic      aligned;
    logic      led_l;
    logic      led_r;
    sample_t   level [5];
    out_item_t expected_beats [$];
    int        errors;
    int        checked;

    function new();
      window  = MatchWindowReset;
      mode    = SEL_NONE;
      aligned = 1'b0;
      led_l   = 1'b0;
      led_r   = 1'b0;
      foreach (level[i]) level[i] = '0;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_window(sample_t w);
      window = w;
    endfunction

    function sample_t level_of(mode_t m);
      return level[int'(m)];
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function void note_sample(in_item_t it);
      mode_t     m;
      sample_t   cur;
      sample_t   gap;
      out_item_t e;
      if (it.switch_light) m = SEL_LIGHT;
      else if (it.switch_speed) m = SEL_SPEED;
      else if (it.switch_offset) m = SEL_OFFSET;
      else if (it.switch_width) m = SEL_WIDTH;
      else m = SEL_NONE;
      if (m != mode) begin
        mode    = m;
        aligned = 1'b0;
      end
      if (m == SEL_NONE) begin
        led_l = 1'b0;
        led_r = 1'b0;
      end else if (aligned) begin
        level[int'(m)] = it.pot_sample;
      end else begin
        cur = level[int'(m)];
        gap = (it.pot_sample >= cur) ? it.pot_sample - cur : cur - it.pot_sample;
        if (gap < window) begin
          led_l   = 1'b1;
          led_r   = 1'b1;
          aligned = 1'b1;
        end else if (it.pot_sample > cur) begin
          led_l = 1'b1;
          led_r = 1'b0;
        end else begin
          led_l = 1'b0;
          led_r = 1'b1;
        end
      end
      e.led_left    = led_l;
      e.led_right   = led_r;
      e.active_mode = mode;
      e.is_aligned  = aligned;
      e.light_out   = level[int'(SEL_LIGHT)];
      e.speed_out   = level[int'(SEL_SPEED)];
      e.offset_out  = level[int'(SEL_OFFSET)];
      e.width_out   = level[int'(SEL_WIDTH)];
      expected_beats.push_back(e);
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, actual %h", $time, got);
        return;
      end
      e = expected_beats.pop_front();
      checked++;
      check_field("led_left", e.led_left, got.led_left);
      check_field("led_right", e.led_right, got.led_right);
      check_field("active_mode", e.active_mode, got.active_mode);
      check_field("is_aligned", e.is_aligned, got.is_aligned);
      check_field("light_out", e.light_out, got.light_out);
      check_field("speed_out", e.speed_out, got.speed_out);
      check_field("offset_out", e.offset_out, got.offset_out);
      check_field("width_out", e.width_out, got.width_out);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  sample_t   cfg_wdata = '0;

  takeover_board sb;
  int  n_sent = 0;
  int  n_windows = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;

  knob_soft_takeover_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // receiver: random stalls, mostly short, a few long
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no beat accepted for %0d cycles", $time, IdleLimit);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [3:0] switches_for(mode_t m);
    logic [3:0] r;
    r = 4'($urandom);
    case (m)
      SEL_LIGHT:  return {1'b1, r[2:0]};
      SEL_SPEED:  return {1'b0, 1'b1, r[1:0]};
      SEL_OFFSET: return {2'b00, 1'b1, r[0]};
      SEL_WIDTH:  return SW_WIDTH;
      default:    return SW_NONE;
    endcase
  endfunction

  task automatic send_sample(sample_t pot, logic [3:0] sw);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {pot, sw};
    sb.note_sample({pot, sw});
    n_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_window(sample_t w);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_window(w);
    n_windows++;
  endtask

  // sweeps: hold one selection, walk the knob toward the stored level, then wander, mixed with single random samples
  task automatic play_random(int n_items);
    int         sent;
    int         run_len;
    int         pot;
    int         step;
    int         delta;
    mode_t      m;
    logic [15:0] raw;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 6) == 0) begin
        raw = 16'($urandom);
        send_sample(raw[15:4], raw[3:0]);
        sent++;
        continue;
      end
      m       = mode_t'($urandom_range(0, 4));
      run_len = $urandom_range(3, 40);
      pot     = $urandom_range(0, SampleMax);
      repeat (run_len) begin
        step  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 800) : $urandom_range(1, 60);
        delta = int'(sb.level_of(m)) - pot;
        if (delta > step) pot += step;
        else if (delta < -step) pot -= step;
        else pot += $urandom_range(0, 2 * step) - step;
        if (pot < 0) pot = 0;
        if (pot > SampleMax) pot = SampleMax;
        send_sample(sample_t'(pot), switches_for(m));
        sent++;
      end
    end
  endtask

  initial begin
    sample_t w;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window: pickup, priority and write-through on each level
    send_sample(12'd4095, SW_NONE);
    send_sample(12'd40, SW_LIGHT);
    send_sample(12'd4095, SW_LIGHT);
    send_sample(12'd0, SW_LIGHT | SW_WIDTH);
    send_sample(12'd41, SW_SPEED);
    send_sample(12'd0, SW_SPEED | SW_OFFSET);
    send_sample(12'hABC, SW_SPEED);
    send_sample(12'd123, SW_ALL);
    send_sample(12'd2048, SW_OFFSET);
    send_sample(12'd40, SW_OFFSET);
    send_sample(12'd4095, SW_OFFSET);
    send_sample(12'd4095, SW_WIDTH);
    send_sample(12'd0, SW_WIDTH);
    send_sample(12'd4095, SW_WIDTH);
    send_sample(12'd0, SW_NONE);

    // zero window never matches, equal knob lights the right led
    write_window(12'd0);
    send_sample(12'd0, SW_LIGHT);
    send_sample(12'd1, SW_LIGHT);

    // full window: only the full-scale gap misses
    write_window(12'd4095);
    send_sample(12'd0, SW_WIDTH);
    send_sample(12'd1, SW_WIDTH);
    send_sample(12'd4095, SW_WIDTH);

    // window of one needs an exact hit
    write_window(12'd1);
    send_sample(12'hABD, SW_SPEED);
    send_sample(12'hABC, SW_SPEED);
    send_sample(12'hABD, SW_SPEED);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       w = MatchWindowReset;
        1:       w = 12'd4095;
        2:       w = 12'd1;
        3:       w = 12'd0;
        default: w = ($urandom_range(0, 2) == 0) ? sample_t'($urandom_range(1, 4095))
                                                  : sample_t'($urandom_range(1, 300));
      endcase
      write_window(w);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      play_random(125);
      // sender holds off until everything in flight has come back
      drain();
      play_random(125);
    end

    drain();
    repeat (4) @(posedge clk);
    $display("checked %0d result beats from %0d samples under %0d match window settings",
             sb.checked, n_sent, n_windows + 1);
    $display("covered pickup, write-through, switch priority and window extremes 0, 1, 4095");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
